/* rtl/lspa_pkg.sv */
// Package with the constants, codes and types shared by the LED strip pulse animator.
package lspa_pkg;

    localparam int STRIP_LENGTH = 256;
    localparam int MAX_PULSE    = 32;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic [8:0]  PHASE_MAX   = 9'd511;
    localparam logic [8:0]  WEIGHT_FULL = 9'd256;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [2:0] REG_STEP_DELAY   = 3'd0;
    localparam logic [2:0] REG_PULSE_LENGTH = 3'd1;
    localparam logic [2:0] REG_REVERSE      = 3'd2;
    localparam logic [2:0] REG_COLOR_RED    = 3'd3;
    localparam logic [2:0] REG_COLOR_GREEN  = 3'd4;
    localparam logic [2:0] REG_COLOR_BLUE   = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_EMPTY
    } state_t;

endpackage

/* rtl/led_strip_pulse_animator_top.sv */
// Top level of the LED strip pulse animator: registers, step sequencer and pixel unit.
//
//  Channel | Direction | Handshake            | Payload
//  cfg     | in        | psel/penable/pready  | paddr, pwdata, prdata (APB-style)
//  in      | in        | in_valid/in_ready    | action, profile_index, profile_weight
//  out     | out       | out_valid/out_ready  | pixel_index, red, green, blue,
//          |           |                      | pixel_valid, pulse_done, last
//
// A load or restart beat is handled in the idle state; a tick that does not step moves
// to the empty state, which sends one empty output beat. A stepping tick walks the pulse
// entries in the pixel unit and, when no pixel lands on the strip, ends with an empty beat.
// An on-strip entry advances only when the output register is free or being taken,
// so a stalled output beat holds the sequencer; in_ready is high only when idle.
// Reset clears control state and the configuration registers; the profile table is not cleared.
module led_strip_pulse_animator_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lspa_pkg::PADDR_W-1:0] paddr,
    input  logic [lspa_pkg::PDATA_W-1:0] pwdata,
    output logic [lspa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [4:0]                   profile_index,
    input  logic [8:0]                   profile_weight,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   pixel_index,
    output logic [7:0]                   red,
    output logic [7:0]                   green,
    output logic [7:0]                   blue,
    output logic                         pixel_valid,
    output logic                         pulse_done,
    output logic                         last
);
    import lspa_pkg::*;

    logic [15:0] step_delay_reg;
    logic [5:0]  pulse_length_reg;
    logic        reverse_reg;
    logic [7:0]  color_red_reg;
    logic [7:0]  color_green_reg;
    logic [7:0]  color_blue_reg;

    state_t      state_reg, state_next;
    logic [5:0]  p_reg, p_next;
    logic [5:0]  size_reg, size_next;
    logic [10:0] base_reg, base_next;
    logic [8:0]  phase_reg, phase_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic        done_reg, done_next;
    logic        out_valid_reg, out_valid_next;

    logic [7:0]  pixel_index_reg, pixel_index_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic        pixel_valid_reg, pixel_valid_next;
    logic        pulse_done_reg, pulse_done_next;
    logic        last_reg, last_next;
    logic        out_load;

    logic [8:0]  weight_table [32];

    logic        cfg_write;
    logic [2:0]  cfg_sel;
    logic        in_fire;
    logic [5:0]  size_w;
    logic [16:0] elapsed_inc;
    logic [8:0]  phase_inc;
    logic [10:0] loc;
    logic        on_strip;
    logic        at_last;
    logic [7:0]  pos;
    logic [8:0]  weight;
    logic [16:0] prod_red;
    logic [16:0] prod_green;
    logic [16:0] prod_blue;

    assign pready    = 1'b1;
    assign cfg_sel   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_delay_reg   <= '0;
            pulse_length_reg <= 6'd1;
            reverse_reg      <= 1'b0;
            color_red_reg    <= '0;
            color_green_reg  <= '0;
            color_blue_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_STEP_DELAY:   step_delay_reg   <= pwdata[15:0];
                REG_PULSE_LENGTH: pulse_length_reg <= pwdata[5:0];
                REG_REVERSE:      reverse_reg      <= pwdata[0];
                REG_COLOR_RED:    color_red_reg    <= pwdata[7:0];
                REG_COLOR_GREEN:  color_green_reg  <= pwdata[7:0];
                REG_COLOR_BLUE:   color_blue_reg   <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_STEP_DELAY:   prdata = {16'd0, step_delay_reg};
            REG_PULSE_LENGTH: prdata = {26'd0, pulse_length_reg};
            REG_REVERSE:      prdata = {31'd0, reverse_reg};
            REG_COLOR_RED:    prdata = {24'd0, color_red_reg};
            REG_COLOR_GREEN:  prdata = {24'd0, color_green_reg};
            REG_COLOR_BLUE:   prdata = {24'd0, color_blue_reg};
            default:          prdata = '0;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = !out_valid_reg || out_ready;

    // The weight table saturates loads at full brightness.
    always_ff @(posedge clk)
    begin
        if (in_fire && action == ACT_LOAD)
        begin
            weight_table[profile_index] <= (profile_weight > WEIGHT_FULL) ? WEIGHT_FULL
                                                                          : profile_weight;
        end
    end

    assign size_w      = (pulse_length_reg > 6'(MAX_PULSE)) ? 6'(MAX_PULSE) : pulse_length_reg;
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 17'd1;
    assign phase_inc   = (phase_reg == PHASE_MAX) ? phase_reg : phase_reg + 9'd1;

    // The pixel unit handles one pulse entry per cycle unless an on-strip entry waits for the output register.
    assign loc      = base_reg + 11'(p_reg);
    assign on_strip = !loc[10] && (loc < 11'(STRIP_LENGTH));
    assign at_last  = (p_reg == size_reg - 6'd1) || (loc == 11'(STRIP_LENGTH - 1));
    assign pos      = reverse_reg ? 8'(11'(STRIP_LENGTH - 1) - loc) : loc[7:0];
    assign weight   = weight_table[p_reg[4:0]];
    assign prod_red   = 17'(weight) * 17'(color_red_reg);
    assign prod_green = 17'(weight) * 17'(color_green_reg);
    assign prod_blue  = 17'(weight) * 17'(color_blue_reg);

    always_comb
    begin
        state_next       = state_reg;
        p_next           = p_reg;
        size_next        = size_reg;
        base_next        = base_reg;
        phase_next       = phase_reg;
        elapsed_next     = elapsed_reg;
        done_next        = done_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        pixel_index_next = pixel_index_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        pixel_valid_next = pixel_valid_reg;
        pulse_done_next  = pulse_done_reg;
        last_next        = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        ACT_TICK:
                        begin
                            if (elapsed_inc > {1'b0, step_delay_reg})
                            begin
                                size_next    = size_w;
                                base_next    = 11'(phase_reg) - 11'(size_w);
                                p_next       = '0;
                                phase_next   = phase_inc;
                                elapsed_next = '0;
                                if ({1'b0, phase_inc} > 10'(STRIP_LENGTH) + 10'(size_w))
                                begin
                                    done_next = 1'b1;
                                end
                                state_next = S_STEP;
                            end
                            else
                            begin
                                elapsed_next = elapsed_inc;
                                state_next   = S_EMPTY;
                            end
                        end
                        ACT_RESTART:
                        begin
                            phase_next   = '0;
                            done_next    = 1'b0;
                            elapsed_next = ELAPSED_MAX;
                        end
                        default: ;
                    endcase
                end
            end
            S_STEP:
            begin
                if (p_reg == size_reg)
                begin
                    state_next = S_EMPTY;
                end
                else if (!on_strip)
                begin
                    p_next = p_reg + 6'd1;
                end
                else if (out_load)
                begin
                    out_valid_next   = 1'b1;
                    pixel_index_next = pos;
                    red_next         = prod_red[15:8];
                    green_next       = prod_green[15:8];
                    blue_next        = prod_blue[15:8];
                    pixel_valid_next = 1'b1;
                    pulse_done_next  = done_reg;
                    last_next        = at_last;
                    p_next           = p_reg + 6'd1;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMPTY:
            begin
                if (out_load)
                begin
                    out_valid_next   = 1'b1;
                    pixel_index_next = '0;
                    red_next         = '0;
                    green_next       = '0;
                    blue_next        = '0;
                    pixel_valid_next = 1'b0;
                    pulse_done_next  = done_reg;
                    last_next        = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p_reg         <= '0;
            size_reg      <= '0;
            base_reg      <= '0;
            phase_reg     <= '0;
            elapsed_reg   <= ELAPSED_MAX;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            size_reg      <= size_next;
            base_reg      <= base_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_index_reg <= pixel_index_next;
        red_reg         <= red_next;
        green_reg       <= green_next;
        blue_reg        <= blue_next;
        pixel_valid_reg <= pixel_valid_next;
        pulse_done_reg  <= pulse_done_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign pixel_valid = pixel_valid_reg;
    assign pulse_done  = pulse_done_reg;
    assign last        = last_reg;

    // Every accepted tick must produce at least one output beat.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && action == ACT_TICK |=> state_reg != S_IDLE)
        else $error("tick accepted without starting a step or an empty beat");

    // The done flag is only cleared by a restart.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !(in_fire && action == ACT_RESTART) |=> done_reg)
        else $error("done flag cleared without a restart");

    // A beat without a pixel is always the final beat of its tick.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pixel_valid_reg |-> last_reg)
        else $error("empty output beat not marked last");

endmodule
